### src/lwos_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwos_pkg
// Shared types and constants for the lattice walker with hook obstacle.
// ----------------------------------------------------------------------------
package lwos_pkg;

    // largest lattice side, in cells
    localparam int LATTICE_MAX = 1024;

    // coordinate and size width, enough for LATTICE_MAX and the 11-bit registers
    localparam int COORD_W = 11;
    // winding counter width
    localparam int WIND_W  = 32;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COORD_W;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [WIND_W-1:0] wind_t;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        GEO_LEFT_HOOK  = 2'd0,
        GEO_RIGHT_HOOK = 2'd1,
        GEO_SYM_HOOK   = 2'd2,
        GEO_NONE       = 2'd3
    } geo_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GEOMETRY_MODE = 3'd0,
        CFG_WIDTH_CELLS   = 3'd1,
        CFG_HOOK_X_SPLIT  = 3'd2,
        CFG_HOOK_X_LOW    = 3'd3,
        CFG_HOOK_X_HIGH   = 3'd4,
        CFG_HEIGHT_CELLS  = 3'd5,
        CFG_HOOK_Y_SPLIT  = 3'd6
    } cfg_idx_t;

    // one result beat
    typedef struct packed {
        coord_t pos_x;
        coord_t pos_y;
        wind_t  winding;
    } result_t;

endpackage

### src/lattice_walker_obstacle_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_walker_obstacle_step
// Walker on a periodic-x, reflecting-y lattice with a configurable hook wall.
// ----------------------------------------------------------------------------
// One direction beat moves the walker by at most one cell and yields one
// result beat carrying the new position and the signed winding count. Steps
// are taken at one per clock while in_stall is low: the walker position and
// winding registers are the only feedback, and the next position is a few
// compares and an increment on them. A result is registered into the output
// register, or into a skid register while the output register holds a waiting
// result, so input keeps flowing while a result waits; input stalls only when
// both hold an untaken result. Configuration registers are written directly by
// cfg_write and are meant to be changed only while no step is in flight.
module lattice_walker_obstacle_step
(
    input  logic                         clk,
    input  logic                         rst_n,

    // configuration write port
    input  logic                         cfg_write,
    input  logic [lwos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lwos_pkg::CFG_DATA_W-1:0] cfg_data,

    // direction beats
    input  logic                         in_valid,
    output logic                         in_stall,
    input  lwos_pkg::dir_t               direction,

    // result beats
    output logic                         out_valid,
    input  logic                         out_stall,
    output lwos_pkg::coord_t             pos_x,
    output lwos_pkg::coord_t             pos_y,
    output lwos_pkg::wind_t              winding
);

    import lwos_pkg::*;

    localparam coord_t MAX_C = COORD_W'(LATTICE_MAX);
    localparam coord_t ONE_C = COORD_W'(1);

    // configuration registers
    geo_mode_t geo_mode_reg;
    coord_t    width_reg;
    coord_t    x_split_reg;
    coord_t    x_low_reg;
    coord_t    x_high_reg;
    coord_t    height_reg;
    coord_t    y_split_reg;

    // walker state
    coord_t cur_x_reg, cur_x_next;
    coord_t cur_y_reg, cur_y_next;
    wind_t  cross_reg, cross_next;

    // result buffering
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    logic    in_accept;
    logic    out_take;
    result_t step_res;

    // working values of the step
    coord_t nx, ny;
    coord_t x, y;
    logic   is_hook, is_sym;
    logic   wall_col;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_mode_reg <= GEO_NONE;
            width_reg    <= COORD_W'(64);
            x_split_reg  <= COORD_W'(32);
            x_low_reg    <= COORD_W'(16);
            x_high_reg   <= COORD_W'(48);
            height_reg   <= COORD_W'(64);
            y_split_reg  <= COORD_W'(32);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_GEOMETRY_MODE: geo_mode_reg <= geo_mode_t'(cfg_data[1:0]);
                CFG_WIDTH_CELLS:   width_reg    <= cfg_data;
                CFG_HOOK_X_SPLIT:  x_split_reg  <= cfg_data;
                CFG_HOOK_X_LOW:    x_low_reg    <= cfg_data;
                CFG_HOOK_X_HIGH:   x_high_reg   <= cfg_data;
                CFG_HEIGHT_CELLS:  height_reg   <= cfg_data;
                CFG_HOOK_Y_SPLIT:  y_split_reg  <= cfg_data;
                default:           ; // unknown index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // step logic
    // ------------------------------------------------------------------
    always_comb
    begin
        // effective lattice size: 0 acts as 1, above max acts as max
        nx = (width_reg == '0) ? ONE_C : ((width_reg > MAX_C) ? MAX_C : width_reg);
        ny = (height_reg == '0) ? ONE_C : ((height_reg > MAX_C) ? MAX_C : height_reg);

        // pull the walker back inside if the lattice shrank
        x = (cur_x_reg == '0) ? ONE_C : ((cur_x_reg > nx) ? nx : cur_x_reg);
        y = (cur_y_reg == '0) ? ONE_C : ((cur_y_reg > ny) ? ny : cur_y_reg);

        is_hook = (geo_mode_reg == GEO_LEFT_HOOK) || (geo_mode_reg == GEO_RIGHT_HOOK);
        is_sym  = (geo_mode_reg == GEO_SYM_HOOK);

        // does the horizontal wall between y_split and y_split+1 cover column x
        case (geo_mode_reg)
            GEO_LEFT_HOOK:  wall_col = (x <= x_split_reg);
            GEO_RIGHT_HOOK: wall_col = (x > x_split_reg);
            GEO_SYM_HOOK:   wall_col = (x >= x_low_reg) && (x <= x_high_reg);
            default:        wall_col = 1'b0;
        endcase

        cur_x_next = x;
        cur_y_next = y;
        cross_next = cross_reg;

        case (direction)
            DIR_RIGHT:
            begin
                if (is_hook && x == nx && y <= y_split_reg)
                begin
                    // wrap blocked by hook
                end
                else if (is_sym && x == x_split_reg && y <= y_split_reg)
                begin
                    // blocked by vertical wall
                end
                else if (x == nx)
                begin
                    cur_x_next = ONE_C;
                    cross_next = cross_reg + WIND_W'(1);
                end
                else
                begin
                    cur_x_next = x + ONE_C;
                end
            end
            DIR_LEFT:
            begin
                if (is_hook && x == ONE_C && y <= y_split_reg)
                begin
                    // wrap blocked by hook
                end
                else if (is_sym && (x - ONE_C) == x_split_reg && y <= y_split_reg)
                begin
                    // blocked by vertical wall
                end
                else if (x == ONE_C)
                begin
                    cur_x_next = nx;
                    cross_next = cross_reg - WIND_W'(1);
                end
                else
                begin
                    cur_x_next = x - ONE_C;
                end
            end
            DIR_UP:
            begin
                if (!(wall_col && y == y_split_reg) && y < ny)
                    cur_y_next = y + ONE_C;
            end
            default:
            begin
                if (!(wall_col && (y - ONE_C) == y_split_reg) && y > ONE_C)
                    cur_y_next = y - ONE_C;
            end
        endcase

        step_res.pos_x   = cur_x_next;
        step_res.pos_y   = cur_y_next;
        step_res.winding = cross_next;
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg <= ONE_C;
            cur_y_reg <= ONE_C;
            cross_reg <= '0;
        end
        else if (in_accept)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            cross_reg <= cross_next;
        end
    end

    // output register and skid register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept;
            end
        end
        else if (in_accept)
        begin
            // result waiting: park the new beat in the skid stage
            if (out_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_accept)
                out_data_reg <= step_res;
        end
        else if (in_accept)
        begin
            if (out_valid_reg)
                skid_data_reg <= step_res;
            else
                out_data_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign pos_x     = out_data_reg.pos_x;
    assign pos_y     = out_data_reg.pos_y;
    assign winding   = out_data_reg.winding;

endmodule

### sim/tb_lattice_walker_obstacle_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_walker_obstacle_step
// Self-checking regression for the lattice walker with hook obstacle.
// ----------------------------------------------------------------------------
// Direction beats go in on a valid/stall channel and every accepted beat is
// run through a walker model kept in a small scoreboard class, which queues
// the expected position and winding. Result beats are compared field by field
// against the oldest expectation. A short directed run covers edge wraps,
// reflection, each hook wall and the size clamps; then random walks run under
// a dozen geometry settings, each with an idle/stall profile, and the
// sender holds off halfway through each setting until every result has come back.
// ----------------------------------------------------------------------------

import lwos_pkg::*;

class walk_scoreboard;

    // configuration copy
    geo_mode_t   geo;
    int unsigned width_reg;
    int unsigned x_split;
    int unsigned x_low;
    int unsigned x_high;
    int unsigned height_reg;
    int unsigned y_split;

    // walker copy
    int unsigned walker_x;
    int unsigned walker_y;
    logic [31:0] crossings;

    result_t     expected_q[$];
    int          mismatches;
    int          steps_checked;
    int          wraps_seen;
    int          blocked_moves;

    function new();
        geo           = GEO_NONE;
        width_reg     = 64;
        x_split       = 32;
        x_low         = 16;
        x_high        = 48;
        height_reg    = 64;
        y_split       = 32;
        walker_x      = 1;
        walker_y      = 1;
        crossings     = '0;
        mismatches    = 0;
        steps_checked = 0;
        wraps_seen    = 0;
        blocked_moves = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GEOMETRY_MODE: geo        = geo_mode_t'(data[1:0]);
            CFG_WIDTH_CELLS:   width_reg  = data;
            CFG_HOOK_X_SPLIT:  x_split    = data;
            CFG_HOOK_X_LOW:    x_low      = data;
            CFG_HOOK_X_HIGH:   x_high     = data;
            CFG_HEIGHT_CELLS:  height_reg = data;
            CFG_HOOK_Y_SPLIT:  y_split    = data;
            default:           ;
        endcase
    endfunction

    function int unsigned fit_size(int unsigned v);
        if (v < 1)
            return 1;
        if (v > LATTICE_MAX)
            return LATTICE_MAX;
        return v;
    endfunction

    // one step of the walker, queues the result it must produce
    function void note_direction(dir_t d);
        int unsigned nx;
        int unsigned ny;
        int unsigned x;
        int unsigned y;
        bit          hook;
        bit          sym;
        bit          wall_col;
        bit          blocked;
        result_t     r;
        nx      = fit_size(width_reg);
        ny      = fit_size(height_reg);
        x       = (walker_x < 1) ? 1 : ((walker_x > nx) ? nx : walker_x);
        y       = (walker_y < 1) ? 1 : ((walker_y > ny) ? ny : walker_y);
        hook    = (geo == GEO_LEFT_HOOK) || (geo == GEO_RIGHT_HOOK);
        sym     = (geo == GEO_SYM_HOOK);
        blocked = 1'b0;
        case (geo)
            GEO_LEFT_HOOK:  wall_col = (x <= x_split);
            GEO_RIGHT_HOOK: wall_col = (x > x_split);
            GEO_SYM_HOOK:   wall_col = (x >= x_low) && (x <= x_high);
            default:        wall_col = 1'b0;
        endcase
        case (d)
            DIR_RIGHT:
            begin
                if ((hook && x == nx && y <= y_split) || (sym && x == x_split && y <= y_split))
                    blocked = 1'b1;
                else if (x == nx)
                begin
                    x = 1;
                    crossings = crossings + 1;
                    wraps_seen++;
                end
                else
                    x = x + 1;
            end
            DIR_LEFT:
            begin
                if ((hook && x == 1 && y <= y_split) || (sym && x - 1 == x_split && y <= y_split))
                    blocked = 1'b1;
                else if (x == 1)
                begin
                    x = nx;
                    crossings = crossings - 1;
                    wraps_seen++;
                end
                else
                    x = x - 1;
            end
            DIR_UP:
            begin
                if (wall_col && y == y_split)
                    blocked = 1'b1;
                else if (y < ny)
                    y = y + 1;
            end
            default:
            begin
                if (wall_col && y - 1 == y_split)
                    blocked = 1'b1;
                else if (y > 1)
                    y = y - 1;
            end
        endcase
        if (blocked)
            blocked_moves++;
        walker_x  = x;
        walker_y  = y;
        r.pos_x   = x[COORD_W-1:0];
        r.pos_y   = y[COORD_W-1:0];
        r.winding = wind_t'(crossings);
        expected_q.push_back(r);
    endfunction

    function void check_result(coord_t x, coord_t y, wind_t w);
        result_t e;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing expected: x=%0d y=%0d w=%0d",
                         $realtime, x, y, w);
            return;
        end
        e = expected_q.pop_front();
        steps_checked++;
        if (x !== e.pos_x || y !== e.pos_y || w !== e.winding)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: step %0d mismatch: exp x=%0d y=%0d w=%0d, got x=%0d y=%0d w=%0d",
                         $realtime, steps_checked, e.pos_x, e.pos_y, e.winding, x, y, w);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void report_leftover();
        if (expected_q.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", expected_q.size());
        end
    endfunction

endclass

module tb_lattice_walker_obstacle_step;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_STEPS    = 150;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    // idle/stall profiles
    typedef enum int {
        PROF_NONE,
        PROF_SEND_IDLE,
        PROF_RECV_STALL,
        PROF_BOTH
    } profile_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    dir_t                  direction = DIR_RIGHT;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    coord_t                pos_x;
    coord_t                pos_y;
    wind_t                 winding;

    walk_scoreboard sb = new();

    // directions still to be sent, front one is on the bus while valid
    dir_t dir_plan[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   settings_run = 0;
    int   idle_cycles = 0;

    lattice_walker_obstacle_step u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .direction (direction),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .winding   (winding)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // receiver: random stall at the rate of the current profile
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // monitor: both channels sampled at the edge, before any update lands
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // check first: a result at this edge belongs to an earlier beat
            if (out_valid && !out_stall)
                sb.check_result(pos_x, pos_y, winding);
            if (in_valid && !in_stall)
                sb.note_direction(direction);
        end
    end

    // watchdog: cycles in a row with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", idle_cycles);
            $display("lattice_walker_obstacle_step regression: fail");
            $finish;
        end
    end

    // one register write, seen by the block at the next edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
    endtask

    // full geometry load, plus a stray write to the unused index
    task automatic apply_geometry(input geo_mode_t mode, input int nx, input int xs,
                                  input int xl, input int xh, input int ny, input int ys);
        logic [CFG_DATA_W-1:0] mode_word;
        // junk above the two mode bits must be dropped
        mode_word = CFG_DATA_W'($urandom_range(0, 511) << 2) | CFG_DATA_W'(mode);
        write_reg(CFG_GEOMETRY_MODE, mode_word);
        write_reg(CFG_WIDTH_CELLS, CFG_DATA_W'(nx));
        write_reg(CFG_HOOK_X_SPLIT, CFG_DATA_W'(xs));
        write_reg(CFG_HOOK_X_LOW, CFG_DATA_W'(xl));
        write_reg(CFG_HOOK_X_HIGH, CFG_DATA_W'(xh));
        write_reg(CFG_HEIGHT_CELLS, CFG_DATA_W'(ny));
        write_reg(CFG_HOOK_Y_SPLIT, CFG_DATA_W'(ys));
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom_range(0, 2047)));
        @(posedge clk);
        cfg_write <= 1'b0;
        settings_run++;
    endtask

    task automatic set_profile(input profile_t p);
        case (p)
            PROF_NONE:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            PROF_SEND_IDLE:  begin send_idle_pct = 58; recv_stall_pct = 0;  end
            PROF_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default:         begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // directed moves written as R/L/U/D letters
    task automatic plan_moves(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            case (s[i])
                "R":     dir_plan.push_back(DIR_RIGHT);
                "L":     dir_plan.push_back(DIR_LEFT);
                "U":     dir_plan.push_back(DIR_UP);
                default: dir_plan.push_back(DIR_DOWN);
            endcase
        end
    endtask

    // random walk, with runs in one direction to push into edges and walls
    task automatic plan_walk(input int count);
        dir_t d;
        int   run;
        while (count > 0)
        begin
            d   = dir_t'($urandom_range(0, 3));
            run = ($urandom_range(99) < 30) ? $urandom_range(2, 12) : 1;
            for (int i = 0; i < run && count > 0; i++)
            begin
                dir_plan.push_back(d);
                count--;
            end
        end
    endtask

    // sender: drains dir_plan, holds the beat steady while stalled
    task automatic run_plan();
        bit taken;
        while (dir_plan.size() > 0 || in_valid)
        begin
            @(posedge clk);
            taken = in_valid && !in_stall;
            if (taken || !in_valid)
            begin
                if (taken)
                    void'(dir_plan.pop_front());
                if (dir_plan.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid  <= 1'b1;
                    direction <= dir_plan[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        geo_mode_t mode;
        int        nx;
        int        ny;
        int        xs;
        int        ys;
        int        xl;
        int        xh;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset geometry, no obstacle: wrap left and back right, reflect at bottom
        set_profile(PROF_NONE);
        plan_moves("LRDUU");
        run_plan();
        wait_drained();

        // left hook on a 4x4: horizontal wall over x<=2, wraps refused low
        apply_geometry(GEO_LEFT_HOOK, 4, 2, 0, 0, 4, 2);
        plan_moves("DRRRDRLLLLU");
        run_plan();
        wait_drained();

        // symmetric hook: step right off the split column, crossbar over 2..4
        apply_geometry(GEO_SYM_HOOK, 6, 3, 2, 4, 3, 1);
        plan_moves("DRRRURL");
        run_plan();
        wait_drained();

        // right hook with zero width and oversized height, hooks at extremes
        apply_geometry(GEO_RIGHT_HOOK, 0, 2047, 1024, 0, 2047, 0);
        plan_moves("RLUD");
        run_plan();
        wait_drained();

        // random walks, one geometry per phase
        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            mode = geo_mode_t'(k % 4);
            nx   = $urandom_range(1, 10);
            ny   = $urandom_range(1, 10);
            case (k)
                2:       nx = 0;
                5:       ny = 0;
                7:       begin nx = 1024; ny = 2047; end
                9:       begin nx = 2047; ny = 1024; end
                default: ;
            endcase
            xs = $urandom_range(0, (nx > 12 ? 12 : nx) + 1);
            ys = $urandom_range(0, (ny > 12 ? 12 : ny) + 1);
            xl = $urandom_range(0, (nx > 12 ? 12 : nx) + 1);
            xh = $urandom_range(0, (nx > 12 ? 12 : nx) + 1);
            case (k)
                4:       begin xs = 2047; xl = 1024; end
                8:       begin xs = 0; ys = 2047; xh = 2047; end
                10:      begin ys = 1024; xl = 0; end
                11:      begin xs = $urandom_range(0, 2047); xh = $urandom_range(0, 2047); end
                default: ;
            endcase
            apply_geometry(mode, nx, xs, xl, xh, ny, ys);
            set_profile(profile_t'((k + k / 4) % 4));
            plan_walk(PHASE_STEPS / 2);
            run_plan();
            // hold off the sender until the block has nothing in flight
            wait_drained();
            plan_walk(PHASE_STEPS - PHASE_STEPS / 2);
            run_plan();
            wait_drained();
        end

        // let any late beat show up before the final count
        repeat (8) @(posedge clk);
        sb.report_leftover();

        $display("checked %0d steps under %0d geometry settings",
                 sb.steps_checked, settings_run);
        $display("walk saw %0d edge wraps and %0d refused moves",
                 sb.wraps_seen, sb.blocked_moves);
        if (sb.mismatches == 0)
            $display("lattice_walker_obstacle_step regression: pass");
        else
            $display("lattice_walker_obstacle_step regression: fail");
        $finish;
    end

endmodule
